// ----- rtl/core/haptic_pulse_pattern_sequencer_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the haptic pulse pattern sequencer
// Clocked on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef HAPTIC_PULSE_PATTERN_SEQUENCER_UNIT_ASSERT_SVH
`define HAPTIC_PULSE_PATTERN_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define HPPS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HPPS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/hpps_pkg.sv -----
// ---------------------------------------------------------------------------
// hpps_pkg
// Shared types, codes and the fixed pattern table of the pulse sequencer.
// ---------------------------------------------------------------------------
package hpps_pkg;

  localparam int unsigned ElapsedW = 16;
  localparam int unsigned TimeW    = 8;   // longest pulse or gap is 200 ms
  localparam int unsigned PulseW   = 3;
  localparam int unsigned CountW   = 4;

  // Function codes of an input word
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_TRIGGER = 2'd1;
  localparam logic [1:0] FUNC_ENABLE  = 2'd2;
  localparam logic [1:0] FUNC_NOP     = 2'd3;

  // Pattern codes
  localparam logic [2:0] PAT_PRESS   = 3'd0;
  localparam logic [2:0] PAT_TIMER   = 3'd1;
  localparam logic [2:0] PAT_GESTURE = 3'd2;
  localparam logic [2:0] PAT_ERROR   = 3'd3;
  localparam logic [2:0] PAT_CYCLE   = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] pattern;
    logic       enable;
  } in_word_t;

  typedef struct packed {
    logic motor_on;
    logic busy_res;
    logic accepted;
    logic pattern_done;
    logic enabled_now;
  } out_word_t;

  // Input stage toward the sequencer core
  typedef struct packed {
    logic     valid;
    in_word_t word;
  } stage_t;

  typedef struct packed {
    logic              known;
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  on_ms;
    logic [TimeW-1:0]  gap_ms;
  } pat_entry_t;

  function automatic pat_entry_t pattern_lookup(input logic [2:0] pat);
    pat_entry_t e;
    e = '0;
    case (pat)
      PAT_PRESS:   e = '{known: 1'b1, count: 4'd1, on_ms: 8'd50,  gap_ms: 8'd0};
      PAT_TIMER:   e = '{known: 1'b1, count: 4'd3, on_ms: 8'd200, gap_ms: 8'd100};
      PAT_GESTURE: e = '{known: 1'b1, count: 4'd1, on_ms: 8'd100, gap_ms: 8'd0};
      PAT_ERROR:   e = '{known: 1'b1, count: 4'd2, on_ms: 8'd50,  gap_ms: 8'd50};
      PAT_CYCLE:   e = '{known: 1'b1, count: 4'd5, on_ms: 8'd80,  gap_ms: 8'd40};
      default:     e = '0;
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/core/haptic_pulse_pattern_sequencer_unit.sv -----
// ---------------------------------------------------------------------------
// haptic_pulse_pattern_sequencer_unit
// Vibration-motor pulse pattern sequencer, one result word per input word.
// ---------------------------------------------------------------------------
// Each input word is a 1 ms tick, a trigger for one of five fixed patterns
// (press, timer, gesture, error, cycle) or an enable change, and it yields
// exactly one result word with the motor drive, busy flag, trigger accept,
// pattern-done pulse and the current enable. A word passes an input
// register, is applied to the sequencer state by combinational logic and
// lands with its result in the output register, and one word per cycle is
// sustained as long as the consumer keeps out_ready_i high. The state
// update (saturating 16-bit elapsed counter, compare against the pulse or
// gap length, phase step) is a single combinational pass and sets that
// rate. MAX_PULSES (5 to 15) caps the pulse count of a pattern.
// ---------------------------------------------------------------------------
module haptic_pulse_pattern_sequencer_unit #(
  parameter int unsigned MAX_PULSES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hpps_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hpps_pkg::out_word_t out_word_o
);
  import hpps_pkg::*;

  stage_t    stage;
  logic      advance;
  out_word_t result;

  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;

  // Advance the held word when the output register is free or drains now.
  assign advance = stage.valid && (!out_valid_q || out_ready_i);

  hpps_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .take_i     (advance),
    .stage_o    (stage)
  );

  hpps_core #(
    .MAX_PULSES (MAX_PULSES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .word_i   (stage.word),
    .result_o (result)
  );

  // Hold the result until taken; drop valid once it drains with nothing new.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- rtl/core/hpps_in_stage.sv -----
// ---------------------------------------------------------------------------
// hpps_in_stage
// Input register: captures one word and holds it until the core takes it.
// ---------------------------------------------------------------------------
module hpps_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hpps_pkg::in_word_t in_word_i,
  input  logic              take_i,
  output hpps_pkg::stage_t  stage_o
);
  import hpps_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q, word_d;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        word_d = in_word_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign stage_o = '{valid: valid_q, word: word_q};

endmodule

// ----- rtl/core/hpps_core.sv -----
// ---------------------------------------------------------------------------
// hpps_core
// Sequencer state and the single-pass update for one word.
// ---------------------------------------------------------------------------
module hpps_core #(
  parameter int unsigned MAX_PULSES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  hpps_pkg::in_word_t  word_i,
  output hpps_pkg::out_word_t result_o
);
  import hpps_pkg::*;

  localparam int unsigned TotalW = $clog2(MAX_PULSES + 1);
  localparam int unsigned CmpW   = 5;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_VIBRATE = 2'd1;
  localparam logic [1:0] PH_PAUSE   = 2'd2;

  logic [1:0]          phase_q, phase_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic [PulseW-1:0]   pulse_num_q, pulse_num_d;
  logic [TotalW-1:0]   pulse_total_q, pulse_total_d;
  logic [TimeW-1:0]    on_time_q, on_time_d;
  logic [TimeW-1:0]    gap_time_q, gap_time_d;
  logic                enabled_q, enabled_d;
  logic                drive_q, drive_d;

  logic                active;
  logic [ElapsedW-1:0] elapsed_inc;
  logic [CmpW-1:0]     next_num;
  pat_entry_t          entry;
  logic                acc, done;

  assign active      = (phase_q == PH_VIBRATE) || (phase_q == PH_PAUSE);
  assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + ElapsedW'(1) : elapsed_q;
  assign next_num    = CmpW'(pulse_num_q) + CmpW'(1);
  assign entry       = pattern_lookup(word_i.pattern);

  always_comb begin
    phase_d       = phase_q;
    elapsed_d     = elapsed_q;
    pulse_num_d   = pulse_num_q;
    pulse_total_d = pulse_total_q;
    on_time_d     = on_time_q;
    gap_time_d    = gap_time_q;
    enabled_d     = enabled_q;
    drive_d       = drive_q;
    acc           = 1'b0;
    done          = 1'b0;
    if (step_i) begin
      unique case (word_i.func)
        FUNC_TICK: begin
          if (phase_q == PH_VIBRATE) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= ElapsedW'(on_time_q)) begin
              drive_d = 1'b0;
              if (next_num < CmpW'(pulse_total_q)) begin
                pulse_num_d = next_num[PulseW-1:0];
                phase_d     = PH_PAUSE;
                elapsed_d   = '0;
              end else begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
          end else if (phase_q == PH_PAUSE) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= ElapsedW'(gap_time_q)) begin
              drive_d   = 1'b1;
              phase_d   = PH_VIBRATE;
              elapsed_d = '0;
            end
          end
        end
        FUNC_TRIGGER: begin
          if (enabled_q && !active && entry.known) begin
            acc         = 1'b1;
            pulse_num_d = '0;
            // clamp the pulse count to the configured limit
            pulse_total_d = (entry.count > CountW'(MAX_PULSES)) ?
                            TotalW'(MAX_PULSES) : TotalW'(entry.count);
            on_time_d   = entry.on_ms;
            gap_time_d  = entry.gap_ms;
            drive_d     = 1'b1;
            phase_d     = PH_VIBRATE;
            elapsed_d   = '0;
          end
        end
        FUNC_ENABLE: begin
          enabled_d = word_i.enable;
          if (!word_i.enable && active) begin
            drive_d = 1'b0;
            phase_d = PH_IDLE;
          end
        end
        FUNC_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      elapsed_q     <= '0;
      pulse_num_q   <= '0;
      pulse_total_q <= '0;
      on_time_q     <= '0;
      gap_time_q    <= '0;
      enabled_q     <= 1'b1;
      drive_q       <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      elapsed_q     <= elapsed_d;
      pulse_num_q   <= pulse_num_d;
      pulse_total_q <= pulse_total_d;
      on_time_q     <= on_time_d;
      gap_time_q    <= gap_time_d;
      enabled_q     <= enabled_d;
      drive_q       <= drive_d;
    end
  end

  assign result_o = '{
    motor_on:     drive_d,
    busy_res:     (phase_d == PH_VIBRATE) || (phase_d == PH_PAUSE),
    accepted:     acc,
    pattern_done: done,
    enabled_now:  enabled_d
  };

endmodule

// ----- rtl/core/hpps_checker.sv -----
// ---------------------------------------------------------------------------
// hpps_checker
// Port-level checks of the pulse sequencer, bound to the top level.
// ---------------------------------------------------------------------------
`include "haptic_pulse_pattern_sequencer_unit_assert.svh"

module hpps_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input hpps_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input hpps_pkg::out_word_t out_word_o
);
  import hpps_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i & in_ready_o & (^in_word_i);

  `HPPS_ASSERT_IMP(a_accept_starts, out_valid_o && out_word_o.accepted, out_word_o.motor_on && out_word_o.busy_res, "accepted trigger did not start the motor")
  `HPPS_ASSERT_IMP(a_done_idle, out_valid_o && out_word_o.pattern_done, !out_word_o.busy_res && !out_word_o.motor_on, "pattern done while still active")
  `HPPS_ASSERT_IMP(a_motor_busy, out_valid_o && out_word_o.motor_on, out_word_o.busy_res, "motor on while idle")
  `HPPS_ASSERT_IMP(a_disabled_idle, out_valid_o && !out_word_o.enabled_now, !out_word_o.busy_res, "pattern active while disabled")
  `HPPS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_word_o), "stalled result word changed")

endmodule

bind haptic_pulse_pattern_sequencer_unit hpps_checker u_hpps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
